FILE: rtl/rmq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int ENTRY_W = 16;  // matrix entry width
  localparam int TRACE_W = 18;  // sum of three entries
  localparam int MAG_W   = 17;  // magnitude of an entry sum or difference
  localparam int QUO_W   = 17;  // quotient bits incl. one overflow bit
  localparam int COMP_W  = 16;  // quaternion component width

  localparam logic [COMP_W-1:0] COMP_MAX = 16'h7fff;
  localparam logic [COMP_W-1:0] COMP_MIN = 16'h8000;

  typedef enum logic [1:0] {
    IDX_W = 2'd0,
    IDX_X = 2'd1,
    IDX_Y = 2'd2,
    IDX_Z = 2'd3
  } comp_idx_t;

  // per-item side data carried along the cell chain
  typedef struct packed {
    comp_idx_t                     idx;
    logic                          degen;
    logic [2:0][MAG_W-1:0]         mag;
    logic [2:0]                    neg;
  } rmq_pay_t;

endpackage

FILE: rtl/rmq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_front
// Trace combinations, largest pick, radicand and entry sums/differences.
// ----------------------------------------------------------------------------
module rmq_front import rmq_pkg::*; #(
  parameter int FRAC_BITS = 14,
  parameter int RAD_W     = 19,
  parameter int V_W       = 30
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  logic signed [ENTRY_W-1:0]  r00, r01, r02,
  input  logic signed [ENTRY_W-1:0]  r10, r11, r12,
  input  logic signed [ENTRY_W-1:0]  r20, r21, r22,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output logic [V_W-1:0]             v_out,
  output rmq_pay_t                   pay_out
);

  logic                       valid_r;
  logic [V_W-1:0]             v_r, v_nxt;
  rmq_pay_t                   pay_r, pay_nxt;

  logic signed [TRACE_W-1:0]  a00, a11, a22;
  logic signed [TRACE_W-1:0]  t0, t1, t2, t3, best;
  logic signed [RAD_W-1:0]    rad;
  logic signed [MAG_W-1:0]    dxw, dyw, dzw, sxy, sxz, syz;
  logic signed [MAG_W-1:0]    d0, d1, d2;
  comp_idx_t                  idx;
  logic                       degen;

  assign a00 = TRACE_W'(r00);
  assign a11 = TRACE_W'(r11);
  assign a22 = TRACE_W'(r22);

  always_comb begin
    t0 = a00 + a11 + a22;
    t1 = a00 - a11 - a22;
    t2 = a11 - a00 - a22;
    t3 = a22 - a00 - a11;
    // strict compare keeps ties on the lower index
    best = t0;
    idx  = IDX_W;
    if (t1 > best) begin
      best = t1;
      idx  = IDX_X;
    end
    if (t2 > best) begin
      best = t2;
      idx  = IDX_Y;
    end
    if (t3 > best) begin
      best = t3;
      idx  = IDX_Z;
    end
    rad   = RAD_W'(best) + (RAD_W'(1) << FRAC_BITS);
    degen = rad[RAD_W-1] || (rad == '0);

    dxw = MAG_W'(r12) - MAG_W'(r21);
    dyw = MAG_W'(r20) - MAG_W'(r02);
    dzw = MAG_W'(r01) - MAG_W'(r10);
    sxy = MAG_W'(r01) + MAG_W'(r10);
    sxz = MAG_W'(r20) + MAG_W'(r02);
    syz = MAG_W'(r12) + MAG_W'(r21);

    unique case (idx)
      IDX_W: begin
        d0 = dxw; d1 = dyw; d2 = dzw;
      end
      IDX_X: begin
        d0 = dxw; d1 = sxy; d2 = sxz;
      end
      IDX_Y: begin
        d0 = dyw; d1 = sxy; d2 = syz;
      end
      default: begin
        d0 = dzw; d1 = sxz; d2 = syz;
      end
    endcase

    pay_nxt.idx    = idx;
    pay_nxt.degen  = degen;
    pay_nxt.neg    = {d2[MAG_W-1], d1[MAG_W-1], d0[MAG_W-1]};
    pay_nxt.mag[0] = d0[MAG_W-1] ? MAG_W'(-d0) : MAG_W'(d0);
    pay_nxt.mag[1] = d1[MAG_W-1] ? MAG_W'(-d1) : MAG_W'(d1);
    pay_nxt.mag[2] = d2[MAG_W-1] ? MAG_W'(-d2) : MAG_W'(d2);
    v_nxt = degen ? '0 : (V_W'(rad[RAD_W-2:0]) << (FRAC_BITS - 2));
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      v_r   <= v_nxt;
      pay_r <= pay_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign v_out    = v_r;
  assign pay_out  = pay_r;

endmodule

FILE: rtl/rmq_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_sqrt_cell
// One root bit of a digit-by-digit integer square root.
// ----------------------------------------------------------------------------
module rmq_sqrt_cell import rmq_pkg::*; #(
  parameter int V_W  = 30,
  parameter int SQ_W = 15
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  logic [V_W-1:0]   v_in,
  input  logic [SQ_W:0]    rem_in,
  input  logic [SQ_W-1:0]  root_in,
  input  rmq_pay_t         pay_in,
  output logic             dn_valid,
  input  logic             dn_ready,
  output logic [V_W-1:0]   v_out,
  output logic [SQ_W:0]    rem_out,
  output logic [SQ_W-1:0]  root_out,
  output rmq_pay_t         pay_out
);

  logic             valid_r;
  logic [V_W-1:0]   v_r;
  logic [SQ_W:0]    rem_r, rem_nxt;
  logic [SQ_W-1:0]  root_r, root_nxt;
  rmq_pay_t         pay_r;
  logic [SQ_W+2:0]  cur, trial, diff;
  logic             ge;

  always_comb begin
    cur      = {rem_in, v_in[V_W-1 -: 2]};
    trial    = {1'b0, root_in, 2'b01};
    diff     = cur - trial;
    ge       = cur >= trial;
    rem_nxt  = ge ? diff[SQ_W:0] : cur[SQ_W:0];
    root_nxt = {root_in[SQ_W-2:0], ge};
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      v_r    <= v_in << 2;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      pay_r  <= pay_in;
    end
  end

  assign dn_valid = valid_r;
  assign v_out    = v_r;
  assign rem_out  = rem_r;
  assign root_out = root_r;
  assign pay_out  = pay_r;

endmodule

FILE: rtl/rmq_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_div_cell
// One quotient bit of a restoring divide, three lanes sharing the divisor.
// ----------------------------------------------------------------------------
module rmq_div_cell import rmq_pkg::*; #(
  parameter int SQ_W  = 15,
  parameter int NUM_W = 34,
  parameter int SHIFT = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  logic [2:0][NUM_W-1:0]       num_in,
  input  logic [2:0][QUO_W-1:0]       quo_in,
  input  logic [SQ_W-1:0]             root_in,
  input  rmq_pay_t                    pay_in,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output logic [2:0][NUM_W-1:0]       num_out,
  output logic [2:0][QUO_W-1:0]       quo_out,
  output logic [SQ_W-1:0]             root_out,
  output rmq_pay_t                    pay_out
);

  logic                        valid_r;
  logic [2:0][NUM_W-1:0]       num_r, num_nxt;
  logic [2:0][QUO_W-1:0]       quo_r, quo_nxt;
  logic [SQ_W-1:0]             root_r;
  rmq_pay_t                    pay_r;
  logic [NUM_W-1:0]            den_sh;

  // divisor is four times the root
  assign den_sh = NUM_W'({root_in, 2'b00}) << SHIFT;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (num_in[i] >= den_sh) begin
        num_nxt[i] = num_in[i] - den_sh;
        quo_nxt[i] = {quo_in[i][QUO_W-2:0], 1'b1};
      end else begin
        num_nxt[i] = num_in[i];
        quo_nxt[i] = {quo_in[i][QUO_W-2:0], 1'b0};
      end
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      num_r  <= num_nxt;
      quo_r  <= quo_nxt;
      root_r <= root_in;
      pay_r  <= pay_in;
    end
  end

  assign dn_valid = valid_r;
  assign num_out  = num_r;
  assign quo_out  = quo_r;
  assign root_out = root_r;
  assign pay_out  = pay_r;

endmodule

FILE: rtl/rmq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_back
// Sign, saturation and component placement into the output register.
// ----------------------------------------------------------------------------
module rmq_back import rmq_pkg::*; #(
  parameter int SQ_W = 15
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  logic [2:0][QUO_W-1:0]  quo_in,
  input  logic [SQ_W-1:0]        root_in,
  input  rmq_pay_t               pay_in,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output logic [3:0][COMP_W-1:0] q_out,
  output logic [1:0]             idx_out,
  output logic                   degen_out
);

  logic                    valid_r;
  logic [3:0][COMP_W-1:0]  q_r, q_nxt;
  logic [1:0]              idx_r;
  logic                    degen_r;
  logic [2:0][COMP_W-1:0]  lane;
  logic [COMP_W-1:0]       big;
  logic [COMP_W-1:0]       mq;
  logic                    ovf;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ovf = quo_in[i][QUO_W-1];
      mq  = quo_in[i][COMP_W-1:0];
      if (pay_in.neg[i]) begin
        lane[i] = (ovf || (mq > COMP_MIN)) ? COMP_MIN : COMP_W'(-mq);
      end else begin
        lane[i] = (ovf || (mq > COMP_MAX)) ? COMP_MAX : mq;
      end
    end
    big = (SQ_W'(root_in) > SQ_W'(COMP_MAX)) ? COMP_MAX : COMP_W'(root_in);
    for (int c = 0; c < 4; c++) begin
      if (pay_in.degen) begin
        q_nxt[c] = '0;
      end else if (c == int'(pay_in.idx)) begin
        q_nxt[c] = big;
      end else if (c < int'(pay_in.idx)) begin
        q_nxt[c] = lane[c];
      end else begin
        q_nxt[c] = lane[c-1];
      end
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      q_r     <= q_nxt;
      idx_r   <= pay_in.idx;
      degen_r <= pay_in.degen;
    end
  end

  assign dn_valid  = valid_r;
  assign q_out     = q_r;
  assign idx_out   = idx_r;
  assign degen_out = degen_r;

endmodule

FILE: rtl/rotation_matrix_to_quaternion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Rotation matrix to unit quaternion, largest-trace method, fixed point.
// ----------------------------------------------------------------------------
// channel  ports                               direction
// in       in_valid/in_ready, in_r00..in_r22   matrix in
// out      out_valid/out_ready, out_q*, flags  quaternion out
//
// Fully pipelined: one transfer per cycle in and out while out_ready is high.
// Stages in order: one front stage, one cell per root bit, seventeen divide
// cells, one output register; SQ_W is 15 at 14 fraction bits.
// Each stage holds until the next one has room, so bubbles close under stalls.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [ENTRY_W-1:0] in_r00, in_r01, in_r02,
  input  logic signed [ENTRY_W-1:0] in_r10, in_r11, in_r12,
  input  logic signed [ENTRY_W-1:0] in_r20, in_r21, in_r22,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [COMP_W-1:0]  out_qw,
  output logic signed [COMP_W-1:0]  out_qx,
  output logic signed [COMP_W-1:0]  out_qy,
  output logic signed [COMP_W-1:0]  out_qz,
  output logic [1:0]                out_largest_component,
  output logic                      out_degenerate
);

  localparam int RAD_W = ((FRAC_BITS + 1 > TRACE_W) ? FRAC_BITS + 1 : TRACE_W) + 1;
  localparam int V_W0  = RAD_W - 1 + FRAC_BITS - 2;
  localparam int V_W   = V_W0 + (V_W0 % 2);
  localparam int SQ_W  = V_W / 2;
  localparam int NUM_A = ((MAG_W + FRAC_BITS > SQ_W + 1) ? MAG_W + FRAC_BITS : SQ_W + 1) + 1;
  localparam int NUM_W = (NUM_A > SQ_W + 2 + QUO_W) ? NUM_A : SQ_W + 2 + QUO_W;

  // square root chain, index 0 is the front stage output
  logic                sq_valid [0:SQ_W];
  logic                sq_ready [0:SQ_W];
  logic [V_W-1:0]      sq_v     [0:SQ_W];
  logic [SQ_W:0]       sq_rem   [0:SQ_W];
  logic [SQ_W-1:0]     sq_root  [0:SQ_W];
  rmq_pay_t            sq_pay   [0:SQ_W];

  // divide chain, index 0 is fed from the end of the root chain
  logic                    dv_valid [0:QUO_W];
  logic                    dv_ready [0:QUO_W];
  logic [2:0][NUM_W-1:0]   dv_num   [0:QUO_W];
  logic [2:0][QUO_W-1:0]   dv_quo   [0:QUO_W];
  logic [SQ_W-1:0]         dv_root  [0:QUO_W];
  rmq_pay_t                dv_pay   [0:QUO_W];

  logic [3:0][COMP_W-1:0]  q_out;

  rmq_front #(
    .FRAC_BITS (FRAC_BITS),
    .RAD_W     (RAD_W),
    .V_W       (V_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .r00      (in_r00), .r01 (in_r01), .r02 (in_r02),
    .r10      (in_r10), .r11 (in_r11), .r12 (in_r12),
    .r20      (in_r20), .r21 (in_r21), .r22 (in_r22),
    .dn_valid (sq_valid[0]),
    .dn_ready (sq_ready[0]),
    .v_out    (sq_v[0]),
    .pay_out  (sq_pay[0])
  );

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar k = 0; k < SQ_W; k++) begin : g_sqrt
    rmq_sqrt_cell #(
      .V_W  (V_W),
      .SQ_W (SQ_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (sq_valid[k]),
      .up_ready (sq_ready[k]),
      .v_in     (sq_v[k]),
      .rem_in   (sq_rem[k]),
      .root_in  (sq_root[k]),
      .pay_in   (sq_pay[k]),
      .dn_valid (sq_valid[k+1]),
      .dn_ready (sq_ready[k+1]),
      .v_out    (sq_v[k+1]),
      .rem_out  (sq_rem[k+1]),
      .root_out (sq_root[k+1]),
      .pay_out  (sq_pay[k+1])
    );
  end

  // dividend: magnitude scaled up plus half the divisor for rounding
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_num[0][i] = (NUM_W'(sq_pay[SQ_W].mag[i]) << FRAC_BITS)
                   + NUM_W'({sq_root[SQ_W], 1'b0});
      dv_quo[0][i] = '0;
    end
  end

  assign dv_valid[0]    = sq_valid[SQ_W];
  assign sq_ready[SQ_W] = dv_ready[0];
  assign dv_root[0]     = sq_root[SQ_W];
  assign dv_pay[0]      = sq_pay[SQ_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    rmq_div_cell #(
      .SQ_W  (SQ_W),
      .NUM_W (NUM_W),
      .SHIFT (QUO_W - 1 - k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (dv_valid[k]),
      .up_ready (dv_ready[k]),
      .num_in   (dv_num[k]),
      .quo_in   (dv_quo[k]),
      .root_in  (dv_root[k]),
      .pay_in   (dv_pay[k]),
      .dn_valid (dv_valid[k+1]),
      .dn_ready (dv_ready[k+1]),
      .num_out  (dv_num[k+1]),
      .quo_out  (dv_quo[k+1]),
      .root_out (dv_root[k+1]),
      .pay_out  (dv_pay[k+1])
    );
  end

  rmq_back #(
    .SQ_W (SQ_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (dv_valid[QUO_W]),
    .up_ready  (dv_ready[QUO_W]),
    .quo_in    (dv_quo[QUO_W]),
    .root_in   (dv_root[QUO_W]),
    .pay_in    (dv_pay[QUO_W]),
    .dn_valid  (out_valid),
    .dn_ready  (out_ready),
    .q_out     (q_out),
    .idx_out   (out_largest_component),
    .degen_out (out_degenerate)
  );

  assign out_qw = q_out[0];
  assign out_qx = q_out[1];
  assign out_qy = q_out[2];
  assign out_qz = q_out[3];

endmodule

FILE: rtl/rmq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_checker
// Port-level checks for the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
module rmq_checker import rmq_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [COMP_W-1:0]  out_qw,
  input logic signed [COMP_W-1:0]  out_qx,
  input logic signed [COMP_W-1:0]  out_qy,
  input logic signed [COMP_W-1:0]  out_qz,
  input logic [1:0]                out_largest_component,
  input logic                      out_degenerate
);

  // a stalled transfer stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_qw) && $stable(out_qx)
      && $stable(out_qy) && $stable(out_qz) && $stable(out_degenerate)
      && $stable(out_largest_component))
    else $error("output payload changed while stalled");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_qw == 0 && out_qx == 0 && out_qy == 0 && out_qz == 0)
    else $error("degenerate result not zeroed");

  // the chosen component is the root, never zero or negative
  a_largest_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_degenerate |->
      (out_largest_component == IDX_W && out_qw > 0)
      || (out_largest_component == IDX_X && out_qx > 0)
      || (out_largest_component == IDX_Y && out_qy > 0)
      || (out_largest_component == IDX_Z && out_qz > 0))
    else $error("largest component not positive");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .out_qw                (out_qw),
  .out_qx                (out_qx),
  .out_qy                (out_qy),
  .out_qz                (out_qz),
  .out_largest_component (out_largest_component),
  .out_degenerate        (out_degenerate)
);
